/* hw/rtl/positional_list_store_macros.svh */
// Assertion macros used by the checker file of the positional list store.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define PLS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list store: assertion failed");

// Delayed implication, sampled on clk_i and disabled during reset.
`define PLS_ASSERT_DLY2(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("positional list store: delayed assertion failed");

`endif

/* hw/rtl/pls_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the list store.
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 7;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_END  = 3'd1,
    MODE_INS_POS  = 3'd2,
    MODE_DEL_HEAD = 3'd3,
    MODE_DEL_END  = 3'd4,
    MODE_DEL_POS  = 3'd5,
    MODE_COUNT    = 3'd6,
    MODE_DUMP     = 3'd7
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_NEXT = 2'd1,
    RD_CUR  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_shift;
    logic    wr_new;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    emit_elem;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_zero;
    logic pos_beyond;
    logic ins_more;
    logic del_more;
    logic dump_last;
  } dp_stat_t;

endpackage

/* hw/rtl/pls_dpath.sv */
// Datapath of the list store: entry memory, count, pointers and result registers.
module pls_dpath import pls_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     result_valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] element_o,
  output logic [LEN_W-1:0]         length_o,
  output logic                     last_o
);

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  tgt_q, tgt_d;
  logic [CNT_W-1:0]  tgt_new;
  logic [CNT_W-1:0]  rd_ptr;
  logic [POS_W-1:0]  cnt_ext;
  logic [CNT_W:0]    ptr_plus1;

  logic                     valid_q;
  logic [STAT_W-1:0]        status_q;
  logic signed [DATA_W-1:0] elem_q;
  logic [LEN_W-1:0]         len_q;
  logic                     last_q;

  assign cnt_ext   = POS_W'(cnt_q);
  assign ptr_plus1 = {1'b0, ptr_q} + (CNT_W+1)'(1);

  always_comb begin
    stat_o.empty      = (cnt_q == '0);
    stat_o.full       = (cnt_q == CNT_W'(CAPACITY));
    stat_o.pos_zero   = (position_i == '0);
    stat_o.pos_beyond = (position_i > cnt_ext);
    stat_o.ins_more   = (ptr_q > tgt_q);
    stat_o.del_more   = (ptr_plus1 < {1'b0, cnt_q});
    stat_o.dump_last  = (ptr_plus1 == {1'b0, cnt_q});
  end

  // Target index of the operation, 0-based; a positional insert past the end appends.
  always_comb begin
    case (mode_e'(mode_i))
      MODE_INS_HEAD, MODE_DEL_HEAD: tgt_new = '0;
      MODE_INS_END: tgt_new = cnt_q;
      MODE_INS_POS: begin
        if (position_i == '0) begin
          tgt_new = '0;
        end else if (position_i > cnt_ext) begin
          tgt_new = cnt_q;
        end else begin
          tgt_new = CNT_W'(position_i - POS_W'(1));
        end
      end
      MODE_DEL_END: tgt_new = cnt_q - CNT_W'(1);
      MODE_DEL_POS: tgt_new = CNT_W'(position_i - POS_W'(1));
      default:      tgt_new = '0;
    endcase
  end

  always_comb begin
    tgt_d = tgt_q;
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (cmd_i.capture) begin
      tgt_d = tgt_new;
      case (mode_e'(mode_i))
        MODE_INS_HEAD, MODE_INS_END, MODE_INS_POS: ptr_d = cnt_q;
        default: ptr_d = tgt_new;
      endcase
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + CNT_W'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - CNT_W'(1);
    end
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PREV: rd_ptr = ptr_q - CNT_W'(1);
      RD_NEXT: rd_ptr = ptr_q + CNT_W'(1);
      RD_CUR:  rd_ptr = ptr_q;
      default: rd_ptr = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ptr_q   <= '0;
      tgt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      tgt_q   <= tgt_d;
      valid_q <= cmd_i.emit;
    end
  end

  // A shift step writes back the word read in the step before.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_ptr[IDX_W-1:0]];
    end
    if (cmd_i.wr_shift) begin
      mem_q[ptr_q[IDX_W-1:0]] <= rdata_q;
    end else if (cmd_i.wr_new) begin
      mem_q[tgt_q[IDX_W-1:0]] <= val_q;
    end
    if (cmd_i.capture) begin
      val_q <= value_i;
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      elem_q   <= cmd_i.emit_elem ? rdata_q : '0;
      last_q   <= cmd_i.emit_elem ? stat_o.dump_last : 1'b1;
      len_q    <= LEN_W'(cnt_q);
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign element_o      = elem_q;
  assign length_o       = len_q;
  assign last_o         = last_q;

endmodule

/* hw/rtl/pls_ctrl.sv */
// Controller state machine that sequences list edits, dumps and responses.
module pls_ctrl import pls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MODE_W-1:0] mode_i,
  input  dp_stat_t          stat_i,
  output dp_cmd_t           cmd_o,
  output logic              busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_WR,
    S_DEL_STEP,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    busy_q;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_CUR;
    cmd_o.status = st_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          st_d = ST_OK;
          case (mode_e'(mode_i))
            MODE_INS_HEAD, MODE_INS_END, MODE_INS_POS: begin
              if (stat_i.full) begin
                st_d    = ST_FULL;
                state_d = S_RESP;
              end else begin
                state_d = S_INS_STEP;
              end
            end
            MODE_DEL_HEAD, MODE_DEL_END: begin
              if (stat_i.empty) begin
                st_d    = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_DEL_STEP;
              end
            end
            MODE_DEL_POS: begin
              if (stat_i.empty) begin
                st_d    = ST_EMPTY;
                state_d = S_RESP;
              end else if (stat_i.pos_zero || stat_i.pos_beyond) begin
                st_d    = ST_BADPOS;
                state_d = S_RESP;
              end else begin
                state_d = S_DEL_STEP;
              end
            end
            MODE_DUMP: begin
              if (stat_i.empty) begin
                st_d    = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_DUMP_RD;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      // Move entries up one place from the tail down to the target, then drop the value in.
      S_INS_STEP: begin
        if (stat_i.ins_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        state_d        = S_INS_STEP;
      end
      // Close the gap by moving later entries down one place.
      S_DEL_STEP: begin
        if (stat_i.del_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_DEL_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = S_DEL_STEP;
      end
      S_DUMP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CUR;
        state_d      = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_elem = 1'b1;
        cmd_o.status    = ST_OK;
        cmd_o.ptr_inc   = 1'b1;
        state_d         = stat_i.dump_last ? S_IDLE : S_DUMP_RD;
      end
      S_RESP: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

/* hw/rtl/positional_list_store.sv */
// Top level of the positional list store: controller plus datapath.
//
//  Channel   Handshake                  Payload
//  command   start_i, busy_o            mode_i, value_i, position_i
//  result    result_valid_o (strobe)    status_o, element_o, length_o, last_o
//
// A command is taken when start_i is high and busy_o is low. Count queries and rejected
// operations go straight to the response state, from which the result is registered. An
// insert or delete does one memory read and one write per moved entry. A dump returns one
// value per entry, last_o on the final one, reading each entry before emitting it.
// Reset empties the list at once. Results appear for one cycle each and are not held off.
module positional_list_store import pls_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     result_valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] element_o,
  output logic [LEN_W-1:0]         length_o,
  output logic                     last_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     ctrl_busy;
  logic     ctrl_start;

  // A new transaction is only presented to the controller while it is idle.
  assign ctrl_start = start_i && !ctrl_busy;
  assign busy_o     = ctrl_busy;

  pls_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_start),
    .mode_i  (mode_i),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (ctrl_busy)
  );

  pls_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .element_o      (element_o),
    .length_o       (length_o),
    .last_o         (last_o)
  );

endmodule

/* hw/rtl/pls_checker.sv */
// Port-level assertion checker for the positional list store, with its bind.
`include "positional_list_store_macros.svh"

module pls_checker import pls_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic [MODE_W-1:0]        mode_i,
  input logic                     result_valid_o,
  input logic [STAT_W-1:0]        status_o,
  input logic signed [DATA_W-1:0] element_o,
  input logic [LEN_W-1:0]         length_o,
  input logic                     last_o
);

  logic count_taken;

  assign count_taken = start_i && !busy_o && (mode_i == MODE_COUNT);

  // The length reported never exceeds the list capacity.
  `PLS_ASSERT_IMP(a_len_bound, result_valid_o, length_o <= LEN_W'(CAPACITY))

  // A count query answers with a single good result that closes its transaction.
  `PLS_ASSERT_DLY2(a_count_latency, count_taken, result_valid_o && last_o && status_o == ST_OK)

  // Error results carry no element and close their transaction.
  `PLS_ASSERT_IMP(a_err_shape, result_valid_o && status_o != ST_OK, element_o == '0 && last_o)

  // The block only goes idle together with the final result of a transaction.
  `PLS_ASSERT_IMP(a_idle_with_last, $fell(busy_o), result_valid_o && last_o)

  // More dump values pending means the block is still busy.
  `PLS_ASSERT_IMP(a_busy_until_last, result_valid_o && !last_o, busy_o)

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);

/* test/positional_list_store_tb.sv */
// Self-checking testbench for the positional list store: directed edge cases and random traffic.
module positional_list_store_tb;
  import pls_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   element;
    logic [LEN_W-1:0]    length;
    logic                last;
  } list_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [MODE_W-1:0]        mode_i;
  logic signed [DATA_W-1:0] value_i;
  logic [POS_W-1:0]         position_i;
  logic                     result_valid_o;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] element_o;
  logic [LEN_W-1:0]         length_o;
  logic                     last_o;

  // Shadow copy of the list contents, head first.
  logic signed [DATA_W-1:0] shadow_list[$];
  list_result_t             pending_results[$];
  list_result_t             want;
  int                       mismatch_count = 0;
  int                       burst_left = 0;

  positional_list_store DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .element_o      (element_o),
    .length_o       (length_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_result(status_e st, logic [DATA_W-1:0] elem, logic fin);
    list_result_t r;
    r.status  = st;
    r.element = elem;
    r.length  = LEN_W'(shadow_list.size());
    r.last    = fin;
    pending_results.push_back(r);
  endfunction

  // Applies one operation to the shadow list and queues the results it must produce.
  function automatic void apply_list_op(mode_e m, logic signed [DATA_W-1:0] v,
                                        logic [POS_W-1:0] p);
    int      n;
    int      idx;
    status_e st;
    n  = shadow_list.size();
    st = ST_OK;
    case (m)
      MODE_INS_HEAD, MODE_INS_END, MODE_INS_POS: begin
        if (n >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          if (m == MODE_INS_HEAD) idx = 0;
          else if (m == MODE_INS_END) idx = n;
          else if (p == 0) idx = 0;
          else idx = (int'(p) - 1 > n) ? n : int'(p) - 1;
          shadow_list.insert(idx, v);
        end
      end
      MODE_DEL_HEAD, MODE_DEL_END, MODE_DEL_POS: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else if (m == MODE_DEL_POS && p == 0) begin
          st = ST_BADPOS;
        end else begin
          if (m == MODE_DEL_HEAD) idx = 0;
          else if (m == MODE_DEL_END) idx = n - 1;
          else idx = int'(p) - 1;
          if (idx >= n) st = ST_BADPOS;
          else shadow_list.delete(idx);
        end
      end
      MODE_DUMP: begin
        if (n == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) push_result(ST_OK, shadow_list[i], i == n - 1);
        end
        return;
      end
      default: st = ST_OK;
    endcase
    push_result(st, '0, 1'b1);
  endfunction

  // Sends one command transaction; the sender can pause between bursts of random length.
  task automatic issue_op(mode_e m, logic signed [DATA_W-1:0] v, logic [POS_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    start_i    = 1'b1;
    mode_i     = m;
    value_i    = v;
    position_i = p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_list_op(m, v, p);
    @(negedge clk_i);
  endtask

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: got status %0d element %0d length %0d last %0b", $realtime, what,
               status_o, element_o, length_o, last_o);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with no transaction pending");
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || element_o !== want.element ||
            length_o !== want.length || last_o !== want.last) begin
          note_mismatch("result mismatch");
          if (mismatch_count <= 10)
            $display("    expected status %0d element %0d length %0d last %0b",
                     want.status, $signed(want.element), want.length, want.last);
        end
      end
    end
  end

  function automatic logic [POS_W-1:0] pick_position();
    int n;
    n = shadow_list.size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return POS_W'($urandom_range(0, 255));
      2:       return POS_W'(n + $urandom_range(1, 3));
      default: return POS_W'($urandom_range(1, n + 1));
    endcase
  endfunction

  task automatic test_empty_list();
    issue_op(MODE_COUNT, 0, 0);
    issue_op(MODE_DUMP, 0, 0);
    issue_op(MODE_DEL_HEAD, 0, 0);
    issue_op(MODE_DEL_END, 0, 0);
    issue_op(MODE_DEL_POS, 0, 1);
  endtask

  task automatic test_insert_positions();
    issue_op(MODE_INS_HEAD, 32'sh7FFF_FFFF, 8'd0);
    issue_op(MODE_INS_END, 32'sh8000_0000, 8'd0);
    issue_op(MODE_INS_POS, -32'sd1, 8'd0);
    issue_op(MODE_INS_POS, 32'sd0, 8'd255);
    issue_op(MODE_INS_POS, 32'sh5A5A_5A5A, 8'd3);
    issue_op(MODE_DEL_POS, 0, 8'd0);
    issue_op(MODE_DEL_POS, 0, 8'd200);
  endtask

  task automatic test_full_list();
    while (shadow_list.size() < CAPACITY)
      issue_op(MODE_INS_POS, $signed($urandom), pick_position());
    issue_op(MODE_INS_HEAD, $signed($urandom), 8'd0);
    issue_op(MODE_INS_END, $signed($urandom), 8'd0);
    issue_op(MODE_INS_POS, $signed($urandom), 8'd1);
    issue_op(MODE_DUMP, $signed($urandom), 8'hFF);
  endtask

  task automatic test_delete_positions();
    issue_op(MODE_DEL_POS, 0, POS_W'(CAPACITY));
    issue_op(MODE_DEL_POS, 0, 8'd7);
    issue_op(MODE_DEL_HEAD, 0, 0);
    issue_op(MODE_DEL_END, 0, 0);
    issue_op(MODE_COUNT, 0, 0);
  endtask

  // Most phases lean toward growing or shrinking so the list keeps reaching full and empty.
  task automatic test_random_traffic(int total);
    int    sent;
    int    phase_len;
    int    grow_pct;
    int    roll;
    mode_e m;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(8, 30);
      case ($urandom_range(0, 2))
        0:       grow_pct = 75;
        1:       grow_pct = 25;
        default: grow_pct = 50;
      endcase
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) m = MODE_DUMP;
        else if (roll < 12) m = MODE_COUNT;
        else if ($urandom_range(0, 99) < grow_pct)
          m = mode_e'(MODE_INS_HEAD + $urandom_range(0, 2));
        else
          m = mode_e'(MODE_DEL_HEAD + $urandom_range(0, 2));
        issue_op(m, $signed($urandom), pick_position());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    mode_i     = MODE_COUNT;
    value_i    = '0;
    position_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_list();
    test_insert_positions();
    test_full_list();
    test_delete_positions();
    test_random_traffic(200);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("positional_list_store_tb: clean");
    end else begin
      $display("positional_list_store_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("positional_list_store_tb: errors");
    $finish;
  end

endmodule
